// ===== rtl/irc_message_tokenizer_top_defines.svh =====
// Assertion macros shared by the IRC tokenizer RTL.
`ifndef IRC_MESSAGE_TOKENIZER_TOP_DEFINES_SVH
`define IRC_MESSAGE_TOKENIZER_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define IRCTOK_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define IRCTOK_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/irctok_pkg.sv =====
// Shared types and constants of the IRC message tokenizer.
package irctok_pkg;

  localparam int CHAR_W   = 16;
  localparam int KIND_W   = 3;
  localparam int PIDX_W   = 4;
  localparam int START_W  = 9;
  localparam int LEN_W    = 10;
  localparam int STATUS_W = 2;

  // Most records one request can cause: four prefix parts and the status.
  localparam int BURST_MAX = 5;
  localparam int BCNT_W    = 3;

  localparam logic [CHAR_W-1:0] CH_SPACE = 16'h0020;
  localparam logic [CHAR_W-1:0] CH_BANG  = 16'h0021;
  localparam logic [CHAR_W-1:0] CH_COLON = 16'h003A;
  localparam logic [CHAR_W-1:0] CH_AT    = 16'h0040;

  localparam logic IN_CHAR = 1'b0;
  localparam logic IN_EOL  = 1'b1;

  localparam logic [KIND_W-1:0] TK_FULL   = 3'd0;
  localparam logic [KIND_W-1:0] TK_NICK   = 3'd1;
  localparam logic [KIND_W-1:0] TK_USER   = 3'd2;
  localparam logic [KIND_W-1:0] TK_HOST   = 3'd3;
  localparam logic [KIND_W-1:0] TK_CMD    = 3'd4;
  localparam logic [KIND_W-1:0] TK_RAW    = 3'd5;
  localparam logic [KIND_W-1:0] TK_PARAM  = 3'd6;
  localparam logic [KIND_W-1:0] TK_STATUS = 3'd7;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_LONG  = 2'd2;

  typedef struct packed {
    logic [KIND_W-1:0]   token_kind;
    logic [PIDX_W-1:0]   param_index;
    logic [START_W-1:0]  start_res;
    logic [LEN_W-1:0]    span_length;
    logic [STATUS_W-1:0] line_status;
    logic                last;
  } rec_t;

  // Records caused by one request, handed from the core to the serializer.
  typedef struct packed {
    logic                      load;
    logic [BCNT_W-1:0]         cnt;
    rec_t [BURST_MAX-1:0]      recs;
  } burst_t;

endpackage

// ===== rtl/irctok_ifs.sv =====
// Valid/ready channel interfaces for characters in and token records out.
interface irctok_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [15:0] character;

  modport source (output valid, kind, character, input ready);
  modport sink   (input valid, kind, character, output ready);
endinterface

interface irctok_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] token_kind;
  logic [3:0] param_index;
  logic [8:0] start_res;
  logic [9:0] span_length;
  logic [1:0] line_status;
  logic       last;

  modport source (output valid, token_kind, param_index, start_res, span_length,
                  line_status, last, input ready);
  modport sink   (input valid, token_kind, param_index, start_res, span_length,
                  line_status, last, output ready);
endinterface

// ===== rtl/irctok_core.sv =====
// Input register, line tokenizer state and per-request record burst.
`include "irc_message_tokenizer_top_defines.svh"

module irctok_core #(
  parameter int MAX_LINE   = 512,
  parameter int MAX_PARAMS = 15
) (
  input  logic                 clk,
  input  logic                 rst,
  irctok_in_if.sink            chars,
  input  logic                 free,
  output irctok_pkg::burst_t   burst
);
  import irctok_pkg::*;

  localparam int PW = $clog2(MAX_LINE + 1);
  localparam int CW = $clog2(MAX_PARAMS + 1);

  typedef enum logic [2:0] {
    PH_LEAD, PH_PREFIX, PH_GAP1, PH_CMD, PH_GAP2, PH_PARAM, PH_GAP3, PH_REST
  } phase_t;

  function automatic rec_t mk_rec(logic [KIND_W-1:0] kind, logic [PIDX_W-1:0] idx,
                                  logic [31:0] start, logic [31:0] len,
                                  logic [STATUS_W-1:0] st, logic lst);
    rec_t r;
    r.token_kind  = kind;
    r.param_index = idx;
    r.start_res   = start[START_W-1:0];
    r.span_length = len[LEN_W-1:0];
    r.line_status = st;
    r.last        = lst;
    return r;
  endfunction

  // Input register
  logic              ivalid;
  logic              ikind;
  logic [CHAR_W-1:0] ichar;

  // Line state
  phase_t          phase, phase_next;
  logic [PW-1:0]   position, position_next;
  logic [PW-1:0]   token_begin, token_begin_next;
  logic [PW-1:0]   prefix_begin, prefix_begin_next;
  logic [PW-1:0]   last_at_pos, last_at_pos_next;
  logic            at_seen, at_seen_next;
  logic [PW-1:0]   last_bang_pos, last_bang_pos_next;
  logic            bang_seen, bang_seen_next;
  logic [PW-1:0]   bang_before_at_pos, bang_before_at_pos_next;
  logic            bang_before_at_seen, bang_before_at_seen_next;
  logic [PW-1:0]   raw_args_begin, raw_args_begin_next;
  logic [CW-1:0]   param_count, param_count_next;
  logic            overflowed, overflowed_next;

  rec_t [BURST_MAX-1:0] recs;
  rec_t [3:0]           pfx;
  logic [BCNT_W-1:0]    cnt;
  logic [BCNT_W-1:0]    slot;
  logic [STATUS_W-1:0]  status;
  logic [CW-1:0]        cnt_inc;
  logic [PIDX_W-1:0]    pidx;
  logic [PW-1:0]        pos_plus1;
  logic [31:0]          pos32, tb32, pb32, at32, bb32, rb32;
  logic                 fire;

  assign pos32     = 32'(position);
  assign tb32      = 32'(token_begin);
  assign pb32      = 32'(prefix_begin);
  assign at32      = 32'(last_at_pos);
  assign bb32      = 32'(bang_before_at_pos);
  assign rb32      = 32'(raw_args_begin);
  assign pos_plus1 = position + PW'(1);
  assign cnt_inc   = param_count + CW'(1);
  assign pidx      = PIDX_W'(32'(param_count) - 32'd1);

  // Prefix split, taken at the current position as its end.
  always_comb begin
    pfx[0] = mk_rec(TK_FULL, '0, pb32, pos32 - pb32, ST_OK, 1'b0);
    if (!at_seen) begin
      pfx[1] = mk_rec(TK_NICK, '0, pb32, pos32 - pb32, ST_OK, 1'b0);
      pfx[2] = mk_rec(TK_USER, '0, 32'd0, 32'd0, ST_OK, 1'b0);
      pfx[3] = mk_rec(TK_HOST, '0, pb32, pos32 - pb32, ST_OK, 1'b0);
    end else begin
      if (bang_before_at_seen) begin
        pfx[1] = mk_rec(TK_NICK, '0, pb32, bb32 - pb32, ST_OK, 1'b0);
        pfx[2] = mk_rec(TK_USER, '0, bb32 + 32'd1, at32 - bb32 - 32'd1, ST_OK, 1'b0);
      end else begin
        pfx[1] = mk_rec(TK_NICK, '0, 32'd0, 32'd0, ST_OK, 1'b0);
        pfx[2] = mk_rec(TK_USER, '0, pb32, at32 - pb32, ST_OK, 1'b0);
      end
      pfx[3] = mk_rec(TK_HOST, '0, at32 + 32'd1, pos32 - at32 - 32'd1, ST_OK, 1'b0);
    end
  end

  always_comb begin
    phase_next               = phase;
    position_next            = position;
    token_begin_next         = token_begin;
    prefix_begin_next        = prefix_begin;
    last_at_pos_next         = last_at_pos;
    at_seen_next             = at_seen;
    last_bang_pos_next       = last_bang_pos;
    bang_seen_next           = bang_seen;
    bang_before_at_pos_next  = bang_before_at_pos;
    bang_before_at_seen_next = bang_before_at_seen;
    raw_args_begin_next      = raw_args_begin;
    param_count_next         = param_count;
    overflowed_next          = overflowed;
    recs   = '0;
    cnt    = '0;
    slot   = '0;
    status = ST_OK;

    if (ikind == IN_EOL) begin
      unique case (phase)
        PH_LEAD, PH_GAP1: status = ST_EMPTY;
        PH_PREFIX: begin
          recs[3:0] = pfx;
          slot      = BCNT_W'(4);
          status    = ST_EMPTY;
        end
        PH_CMD: begin
          recs[0] = mk_rec(TK_CMD, '0, tb32, pos32 - tb32, ST_OK, 1'b0);
          slot    = BCNT_W'(1);
        end
        PH_GAP2: status = ST_OK;
        PH_GAP3: begin
          recs[0] = mk_rec(TK_RAW, '0, rb32, pos32 - rb32, ST_OK, 1'b0);
          slot    = BCNT_W'(1);
        end
        PH_PARAM, PH_REST: begin
          recs[0] = mk_rec(TK_RAW, '0, rb32, pos32 - rb32, ST_OK, 1'b0);
          recs[1] = mk_rec(TK_PARAM, pidx, tb32, pos32 - tb32, ST_OK, 1'b0);
          slot    = BCNT_W'(2);
        end
      endcase
      if (overflowed) status = ST_LONG;
      recs[slot] = mk_rec(TK_STATUS, '0, 32'd0, 32'd0, status, 1'b1);
      cnt        = slot + BCNT_W'(1);
      // Back to the reset state for the next line.
      phase_next               = PH_LEAD;
      position_next            = '0;
      token_begin_next         = '0;
      prefix_begin_next        = '0;
      last_at_pos_next         = '0;
      at_seen_next             = 1'b0;
      last_bang_pos_next       = '0;
      bang_seen_next           = 1'b0;
      bang_before_at_pos_next  = '0;
      bang_before_at_seen_next = 1'b0;
      raw_args_begin_next      = '0;
      param_count_next         = '0;
      overflowed_next          = 1'b0;
    end else if (pos32 >= MAX_LINE) begin
      overflowed_next = 1'b1;
    end else begin
      position_next = pos_plus1;
      unique case (phase)
        PH_LEAD: begin
          priority if (ichar == CH_SPACE) begin
          end else if (ichar == CH_COLON) begin
            prefix_begin_next        = pos_plus1;
            at_seen_next             = 1'b0;
            bang_seen_next           = 1'b0;
            bang_before_at_seen_next = 1'b0;
            phase_next               = PH_PREFIX;
          end else begin
            token_begin_next = position;
            phase_next       = PH_CMD;
          end
        end
        PH_PREFIX: begin
          priority if (ichar == CH_SPACE) begin
            recs[3:0]  = pfx;
            cnt        = BCNT_W'(4);
            phase_next = PH_GAP1;
          end else if (ichar == CH_AT && position > prefix_begin) begin
            last_at_pos_next         = position;
            at_seen_next             = 1'b1;
            bang_before_at_pos_next  = last_bang_pos;
            bang_before_at_seen_next = bang_seen;
          end else if (ichar == CH_BANG) begin
            last_bang_pos_next = position;
            bang_seen_next     = 1'b1;
          end else begin
          end
        end
        PH_GAP1: begin
          if (ichar != CH_SPACE) begin
            token_begin_next = position;
            phase_next       = PH_CMD;
          end
        end
        PH_CMD: begin
          if (ichar == CH_SPACE) begin
            recs[0]    = mk_rec(TK_CMD, '0, tb32, pos32 - tb32, ST_OK, 1'b0);
            cnt        = BCNT_W'(1);
            phase_next = PH_GAP2;
          end
        end
        PH_PARAM: begin
          if (ichar == CH_SPACE) begin
            recs[0]    = mk_rec(TK_PARAM, pidx, tb32, pos32 - tb32, ST_OK, 1'b0);
            cnt        = BCNT_W'(1);
            phase_next = PH_GAP3;
          end
        end
        PH_GAP2, PH_GAP3: begin
          if (ichar != CH_SPACE) begin
            if (phase == PH_GAP2) raw_args_begin_next = position;
            param_count_next = cnt_inc;
            priority if (32'(cnt_inc) >= MAX_PARAMS) begin
              token_begin_next = position;
              phase_next       = PH_REST;
            end else if (ichar == CH_COLON) begin
              token_begin_next = pos_plus1;
              phase_next       = PH_REST;
            end else begin
              token_begin_next = position;
              phase_next       = PH_PARAM;
            end
          end
        end
        PH_REST: phase_next = PH_REST;
      endcase
    end
  end

  // Advance when nothing is caused or the serializer can take the burst.
  assign fire        = ivalid && (cnt == '0 || free);
  assign chars.ready = !ivalid || fire;

  assign burst.load = fire && (cnt != '0);
  assign burst.cnt  = cnt;
  assign burst.recs = recs;

  always_ff @(posedge clk) begin
    if (rst) begin
      ivalid <= 1'b0;
    end else if (chars.valid && chars.ready) begin
      ivalid <= 1'b1;
    end else if (fire) begin
      ivalid <= 1'b0;
    end
    if (chars.valid && chars.ready) begin
      ikind <= chars.kind;
      ichar <= chars.character;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase               <= PH_LEAD;
      position            <= '0;
      token_begin         <= '0;
      prefix_begin        <= '0;
      last_at_pos         <= '0;
      at_seen             <= 1'b0;
      last_bang_pos       <= '0;
      bang_seen           <= 1'b0;
      bang_before_at_pos  <= '0;
      bang_before_at_seen <= 1'b0;
      raw_args_begin      <= '0;
      param_count         <= '0;
      overflowed          <= 1'b0;
    end else if (fire) begin
      phase               <= phase_next;
      position            <= position_next;
      token_begin         <= token_begin_next;
      prefix_begin        <= prefix_begin_next;
      last_at_pos         <= last_at_pos_next;
      at_seen             <= at_seen_next;
      last_bang_pos       <= last_bang_pos_next;
      bang_seen           <= bang_seen_next;
      bang_before_at_pos  <= bang_before_at_pos_next;
      bang_before_at_seen <= bang_before_at_seen_next;
      raw_args_begin      <= raw_args_begin_next;
      param_count         <= param_count_next;
      overflowed          <= overflowed_next;
    end
  end

  `IRCTOK_ASSERT_NEXT(a_eol_clears_line, fire && ikind == IN_EOL, phase == PH_LEAD && position == '0 && !overflowed, "line state not cleared after end of line")
  `IRCTOK_ASSERT_NOW(a_overflow_at_limit, overflowed, 32'(position) == MAX_LINE, "overflow flagged below the line limit")
  `IRCTOK_ASSERT_NOW(a_eol_ends_with_status, burst.load && ikind == IN_EOL, recs[cnt - BCNT_W'(1)].last, "end-of-line burst lacks its status record")

endmodule

// ===== rtl/irctok_serializer.sv =====
// Result register that hands out a record burst one record per cycle while tokens.ready is high.
`include "irc_message_tokenizer_top_defines.svh"

module irctok_serializer (
  input  logic                clk,
  input  logic                rst,
  input  irctok_pkg::burst_t  burst,
  output logic                free,
  irctok_out_if.source        tokens
);
  import irctok_pkg::*;

  rec_t [BURST_MAX-1:0] recs;
  logic [BCNT_W-1:0]    idx;
  logic [BCNT_W-1:0]    rem;
  rec_t                 cur;

  assign cur  = recs[idx];
  assign free = (rem == '0) || (rem == BCNT_W'(1) && tokens.ready);

  assign tokens.valid       = (rem != '0);
  assign tokens.token_kind  = cur.token_kind;
  assign tokens.param_index = cur.param_index;
  assign tokens.start_res   = cur.start_res;
  assign tokens.span_length = cur.span_length;
  assign tokens.line_status = cur.line_status;
  assign tokens.last        = cur.last;

  always_ff @(posedge clk) begin
    if (rst) begin
      rem <= '0;
      idx <= '0;
    end else if (burst.load) begin
      rem <= burst.cnt;
      idx <= '0;
    end else if (tokens.valid && tokens.ready) begin
      rem <= rem - BCNT_W'(1);
      idx <= idx + BCNT_W'(1);
    end
    if (burst.load) begin
      recs <= burst.recs;
    end
  end

  `IRCTOK_ASSERT_NOW(a_load_when_free, burst.load, free, "burst loaded over undelivered records")
  `IRCTOK_ASSERT_NOW(a_status_closes_burst, tokens.valid && cur.last, rem == BCNT_W'(1), "status record is not the last of its burst")
  `IRCTOK_ASSERT_NOW(a_burst_in_range, tokens.valid, 32'(idx) + 32'(rem) <= BURST_MAX, "serializer index ran past the burst")

endmodule

// ===== rtl/irc_message_tokenizer_top.sv =====
// Top level of the IRC message line tokenizer.
//
//   channel  dir  payload                                          accepted when
//   chars    in   kind, character                                  valid && ready
//   tokens   out  token_kind, param_index, start_res, span_length,  valid && ready
//                 line_status, last
//
// Flow: one character per cycle into the input register while chars.ready is
//   high; the core works it in the next cycle, held while its burst waits.
// A request causing records (prefix close 4, end of line 1 to 5) loads them as a
//   burst into the serializer; it puts them out in turn on the tokens port.
// Reset: rst is synchronous; it clears the input valid, the line state and the
//   serializer counts. No clearing pass, the block is ready the cycle after.
// Stalls: tokens.ready low holds the burst, then the core, then chars.ready.
module irc_message_tokenizer_top #(
  parameter int MAX_LINE   = 512,
  parameter int MAX_PARAMS = 15
) (
  input  logic          clk,
  input  logic          rst,
  irctok_in_if.sink     chars,
  irctok_out_if.source  tokens
);
  import irctok_pkg::*;

  burst_t burst;
  logic   free;

  // Tokenizer: input register, line state, records caused by each request.
  irctok_core #(
    .MAX_LINE   (MAX_LINE),
    .MAX_PARAMS (MAX_PARAMS)
  ) u_core (
    .clk   (clk),
    .rst   (rst),
    .chars (chars),
    .free  (free),
    .burst (burst)
  );

  // Result register: drain the burst one record per accepted output.
  irctok_serializer u_ser (
    .clk    (clk),
    .rst    (rst),
    .burst  (burst),
    .free   (free),
    .tokens (tokens)
  );

endmodule
